// ----- design/clock_page_replacement_core_assert.svh -----
// Assertion macros used by the clock replacement datapath.
// Expects clk and arst_n in the scope of each use.
`ifndef CLOCK_PAGE_REPLACEMENT_CORE_ASSERT_SVH
`define CLOCK_PAGE_REPLACEMENT_CORE_ASSERT_SVH

// same-cycle implication
`define CPRC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cprc assertion failed");

// next-cycle implication
`define CPRC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cprc assertion failed");

`endif

// ----- design/cprc_pkg.sv -----
// Package for the clock replacement core: beat payloads, opcodes,
// controller-to-datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package cprc_pkg;

	localparam int PN_W   = 20;
	localparam int SLOT_W = 3;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_ACCESS = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		RES_ZERO  = 2'd0,
		RES_HIT   = 2'd1,
		RES_FILL  = 2'd2,
		RES_EVICT = 2'd3
	} res_kind_t;

	typedef struct packed {
		op_t              op;
		logic [PN_W-1:0]  page_number;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              found;
		logic              evicted_valid;
		logic [PN_W-1:0]   evicted_page;
	} rsp_t;

	typedef struct packed {
		logic      load;
		logic      clear;
		logic      scan_rd;
		logic      hit_set;
		logic      fill;
		logic      sweep;
		logic      vic_rd;
		logic      vic_wr;
		logic      res_load;
		res_kind_t kind;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic scan_last;
		logic hit;
		logic empty;
		logic ref_at_hand;
	} sts_t;

endpackage

// ----- design/cprc_ctrl.sv -----
// Controller FSM for the clock replacement core.
// Depends on cprc_pkg; drives cmd_t to cprc_datapath, reads sts_t.
`timescale 1ns / 1ps

module cprc_ctrl import cprc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic out_free,
	input  sts_t sts,
	output cmd_t cmd,
	output logic idle
);

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_DISPATCH = 7'b0000010,
		S_SCAN     = 7'b0000100,
		S_TAIL     = 7'b0001000,
		S_DECIDE   = 7'b0010000,
		S_SWEEP    = 7'b0100000,
		S_VICTIM   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.kind = RES_ZERO;
		idle     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				idle = 1'b1;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (sts.op inside {OP_INSERT, OP_ACCESS}) begin
					state_d = S_SCAN;
				end else if (out_free) begin
					cmd.clear    = (sts.op == OP_CLEAR);
					cmd.res_load = 1'b1;
					cmd.kind     = RES_ZERO;
					state_d      = S_IDLE;
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) begin
					state_d = S_TAIL;
				end
			end
			S_TAIL: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.hit) begin
					if (out_free) begin
						cmd.hit_set  = 1'b1;
						cmd.res_load = 1'b1;
						cmd.kind     = RES_HIT;
						state_d      = S_IDLE;
					end
				end else if (sts.op == OP_ACCESS) begin
					if (out_free) begin
						cmd.res_load = 1'b1;
						cmd.kind     = RES_ZERO;
						state_d      = S_IDLE;
					end
				end else if (sts.empty) begin
					if (out_free) begin
						cmd.fill     = 1'b1;
						cmd.res_load = 1'b1;
						cmd.kind     = RES_FILL;
						state_d      = S_IDLE;
					end
				end else begin
					state_d = S_SWEEP;
				end
			end
			S_SWEEP: begin
				if (sts.ref_at_hand) begin
					cmd.sweep = 1'b1;
				end else begin
					cmd.vic_rd = 1'b1;
					state_d    = S_VICTIM;
				end
			end
			S_VICTIM: begin
				if (out_free) begin
					cmd.vic_wr   = 1'b1;
					cmd.res_load = 1'b1;
					cmd.kind     = RES_EVICT;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- design/cprc_datapath.sv -----
// Datapath: page store memory, valid and reference bits, clock hand, scan compare.
// Depends on cprc_pkg and clock_page_replacement_core_assert.svh.
`timescale 1ns / 1ps
`include "clock_page_replacement_core_assert.svh"

module cprc_datapath import cprc_pkg::*; #(
	parameter int SLOTS     = 8,
	parameter int PAGE_BITS = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  req_t req,
	input  cmd_t cmd,
	output sts_t sts,
	output rsp_t res
);

	localparam int IDX_W  = $clog2(SLOTS);
	localparam int KEEP_W = (PAGE_BITS < PN_W) ? PAGE_BITS : PN_W;
	localparam int SO_W   = (IDX_W < SLOT_W) ? IDX_W : SLOT_W;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] x);
		return (x == LAST) ? '0 : x + 1'b1;
	endfunction

	function automatic logic [SLOT_W-1:0] slot_out(input logic [IDX_W-1:0] x);
		logic [SLOT_W-1:0] s;
		s = '0;
		s[SO_W-1:0] = x[SO_W-1:0];
		return s;
	endfunction

	logic [PAGE_BITS-1:0] mem [SLOTS];
	logic [PAGE_BITS-1:0] rdata_q;
	logic [PAGE_BITS-1:0] pn_in, pn_q;
	op_t                  op_q;
	logic [SLOTS-1:0]     valid_q, ref_q;
	logic [IDX_W-1:0]     hand_q, idx_q, idx_s1, hit_idx_q, emp_idx_q;
	logic                 vld_s1, hit_q, emp_q;
	logic                 cmp_hit, cmp_emp;
	logic                 rd_en, wr_en;
	logic [IDX_W-1:0]     rd_addr, wr_addr;
	logic [PN_W-1:0]      ev_page;

	always_comb begin
		pn_in = '0;
		pn_in[KEEP_W-1:0] = req.page_number[KEEP_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= req.op;
			pn_q <= pn_in;
		end
	end

	// page store
	assign rd_en   = cmd.scan_rd | cmd.vic_rd;
	assign rd_addr = cmd.vic_rd ? hand_q : idx_q;
	assign wr_en   = cmd.fill | cmd.vic_wr;
	assign wr_addr = cmd.vic_wr ? hand_q : emp_idx_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= pn_q;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// scan pipeline
	assign cmp_hit = vld_s1 & valid_q[idx_s1] & (rdata_q == pn_q);
	assign cmp_emp = vld_s1 & ~valid_q[idx_s1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			idx_s1    <= '0;
			vld_s1    <= 1'b0;
			hit_q     <= 1'b0;
			emp_q     <= 1'b0;
			hit_idx_q <= '0;
			emp_idx_q <= '0;
		end else begin
			vld_s1 <= cmd.scan_rd;
			idx_s1 <= idx_q;
			if (cmd.load) begin
				idx_q <= '0;
				hit_q <= 1'b0;
				emp_q <= 1'b0;
			end else begin
				if (cmd.scan_rd) begin
					idx_q <= wrap_inc(idx_q);
				end
				if (cmp_hit && !hit_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= idx_s1;
				end
				if (cmp_emp && !emp_q) begin
					emp_q     <= 1'b1;
					emp_idx_q <= idx_s1;
				end
			end
		end
	end

	// slot state and hand
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ref_q   <= '0;
			hand_q  <= '0;
		end else begin
			if (cmd.clear) begin
				valid_q <= '0;
				ref_q   <= '0;
				hand_q  <= '0;
			end
			if (cmd.hit_set) begin
				ref_q[hit_idx_q] <= 1'b1;
			end
			if (cmd.fill) begin
				valid_q[emp_idx_q] <= 1'b1;
				ref_q[emp_idx_q]   <= 1'b1;
			end
			if (cmd.sweep) begin
				ref_q[hand_q] <= 1'b0;
				hand_q        <= wrap_inc(hand_q);
			end
			if (cmd.vic_wr) begin
				valid_q[hand_q] <= 1'b1;
				ref_q[hand_q]   <= 1'b1;
				hand_q          <= wrap_inc(hand_q);
			end
		end
	end

	assign sts.op          = op_q;
	assign sts.scan_last   = (idx_q == LAST);
	assign sts.hit         = hit_q;
	assign sts.empty       = emp_q;
	assign sts.ref_at_hand = ref_q[hand_q];

	always_comb begin
		ev_page = '0;
		ev_page[KEEP_W-1:0] = rdata_q[KEEP_W-1:0];
	end

	always_comb begin
		res = '0;
		case (cmd.kind)
			RES_HIT: begin
				res.slot  = slot_out(hit_idx_q);
				res.found = 1'b1;
			end
			RES_FILL: begin
				res.slot  = slot_out(emp_idx_q);
				res.found = 1'b1;
			end
			RES_EVICT: begin
				res.slot          = slot_out(hand_q);
				res.found         = 1'b1;
				res.evicted_valid = 1'b1;
				res.evicted_page  = ev_page;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	`CPRC_ASSERT_NOW(a_victim_ok, cmd.vic_wr, valid_q[hand_q] && !ref_q[hand_q])
	`CPRC_ASSERT_NOW(a_fill_empty, cmd.fill, emp_q && !valid_q[emp_idx_q])
	`CPRC_ASSERT_NOW(a_hit_known, cmd.hit_set, hit_q && valid_q[hit_idx_q])
	`CPRC_ASSERT_NEXT(a_clear_done, cmd.clear, (valid_q == '0) && (hand_q == '0))

endmodule

// ----- design/clock_page_replacement_core.sv -----
// Clock (second chance) replacement working set: top level with beat handshake.
// Clear/no-op load a result from dispatch; insert/access scan the store one slot per cycle;
// an insert into a full store then clears each set reference bit at the hand (up to SLOTS)
// before it evicts the slot at the hand. A new item is accepted only when idle.
// Reset: arst_n clears valid and reference bits, hand and control; page store is not cleared.
`timescale 1ns / 1ps

module clock_page_replacement_core import cprc_pkg::*; #(
	parameter int SLOTS     = 8,
	parameter int PAGE_BITS = 20
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	cmd_t cmd;
	sts_t sts;
	rsp_t res;
	logic idle;
	logic out_free;
	logic rsp_valid_q;
	rsp_t rsp_q;

	assign req_stall = ~idle;
	assign out_free  = ~rsp_valid_q | ~rsp_stall;

	cprc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (req_valid),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd),
		.idle     (idle)
	);

	cprc_datapath #(
		.SLOTS     (SLOTS),
		.PAGE_BITS (PAGE_BITS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.res    (res)
	);

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for clock_page_replacement_core: directed and random
// insert/access/clear/no-op beats checked against an in-bench clock replacement predictor.
// Depends on cprc_pkg and the core RTL.
`timescale 1ns / 1ps

module testbench;
	import cprc_pkg::*;

	localparam int NSLOT        = 8;
	localparam int POOL_SIZE    = 12;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 48;
	localparam int REPORT_LIMIT = 10;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int idle_pct  = 0;
	int stall_pct = 0;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int mismatches = 0;
	int beat_count = 0;

	logic [PN_W-1:0]   ws_page [NSLOT];
	bit                ws_held [NSLOT];
	bit                ws_ref  [NSLOT];
	logic [SLOT_W-1:0] ws_hand;
	logic [PN_W-1:0]   page_pool [POOL_SIZE];

	rsp_t pending_replies [$];
	rsp_t want_rsp;

	clock_page_replacement_core #(.SLOTS(NSLOT), .PAGE_BITS(PN_W)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1_500_000;
		$display("status: fail");
		$finish;
	end

	function automatic void reset_working_set();
		int i;
		for (i = 0; i < NSLOT; i++) begin
			ws_page[i] = '0;
			ws_held[i] = 1'b0;
			ws_ref[i]  = 1'b0;
		end
		ws_hand = '0;
	endfunction

	function automatic rsp_t apply_page_op(req_t item);
		rsp_t r;
		int   i;
		int   hit;
		int   free;
		int   h;
		int   n;
		bit   done;
		r    = '0;
		hit  = -1;
		free = -1;
		for (i = NSLOT - 1; i >= 0; i--) begin
			if (ws_held[i] && ws_page[i] == item.page_number)
				hit = i;
			if (!ws_held[i])
				free = i;
		end
		case (item.op)
			OP_INSERT: begin
				if (hit >= 0) begin
					ws_ref[hit] = 1'b1;
					r.slot  = SLOT_W'(hit);
					r.found = 1'b1;
				end else if (free >= 0) begin
					ws_page[free] = item.page_number;
					ws_held[free] = 1'b1;
					ws_ref[free]  = 1'b1;
					r.slot  = SLOT_W'(free);
					r.found = 1'b1;
				end else begin
					h    = ws_hand;
					done = 1'b0;
					for (n = 0; n <= NSLOT && !done; n++) begin
						if (ws_ref[h]) begin
							ws_ref[h] = 1'b0;
							h = (h + 1) % NSLOT;
						end else begin
							r.evicted_page  = ws_page[h];
							r.evicted_valid = 1'b1;
							r.found         = 1'b1;
							r.slot          = SLOT_W'(h);
							ws_page[h] = item.page_number;
							ws_held[h] = 1'b1;
							ws_ref[h]  = 1'b1;
							ws_hand    = SLOT_W'((h + 1) % NSLOT);
							done       = 1'b1;
						end
					end
				end
			end
			OP_ACCESS: begin
				if (hit >= 0) begin
					ws_ref[hit] = 1'b1;
					r.slot  = SLOT_W'(hit);
					r.found = 1'b1;
				end
			end
			OP_CLEAR: begin
				for (i = 0; i < NSLOT; i++) begin
					ws_held[i] = 1'b0;
					ws_ref[i]  = 1'b0;
				end
				ws_hand = '0;
			end
			default: ;
		endcase
		return r;
	endfunction

	// receiver stall, with a long hold-off whenever hold_asks moves
	always @(negedge clk) begin
		if (hold_asks != hold_seen) begin
			hold_seen <= hold_asks;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			beat_count <= beat_count + 1;
			if (pending_replies.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < REPORT_LIMIT)
					$display("beat %0d: unexpected result slot %0d found %0b ev %0b page %h",
						beat_count, rsp.slot, rsp.found, rsp.evicted_valid, rsp.evicted_page);
			end else begin
				want_rsp = pending_replies.pop_front();
				if (rsp.slot !== want_rsp.slot || rsp.found !== want_rsp.found ||
						rsp.evicted_valid !== want_rsp.evicted_valid ||
						rsp.evicted_page !== want_rsp.evicted_page) begin
					mismatches <= mismatches + 1;
					if (mismatches < REPORT_LIMIT)
						$display("beat %0d: exp slot %0d found %0b ev %0b page %h, got slot %0d found %0b ev %0b page %h",
							beat_count, want_rsp.slot, want_rsp.found, want_rsp.evicted_valid,
							want_rsp.evicted_page, rsp.slot, rsp.found, rsp.evicted_valid,
							rsp.evicted_page);
				end
			end
		end
	end

	task automatic send_item(input req_t item);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		do @(posedge clk); while (req_stall);
		pending_replies.push_back(apply_page_op(item));
	endtask

	task automatic send_op(input op_t op, input logic [PN_W-1:0] page);
		req_t item;
		item.op          = op;
		item.page_number = page;
		send_item(item);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	function automatic req_t random_item();
		req_t it;
		int   pick;
		pick = $urandom_range(99);
		if (pick < 50)
			it.op = OP_INSERT;
		else if (pick < 94)
			it.op = OP_ACCESS;
		else if (pick < 98)
			it.op = OP_NOP;
		else
			it.op = OP_CLEAR;
		if ($urandom_range(99) < 80)
			it.page_number = page_pool[$urandom_range(POOL_SIZE - 1)];
		else
			it.page_number = PN_W'($urandom);
		return it;
	endfunction

	task automatic refill_pool();
		int i;
		for (i = 0; i < POOL_SIZE; i++)
			page_pool[i] = PN_W'($urandom);
	endtask

	task automatic test_directed();
		idle_pct  = 0;
		stall_pct = 0;
		send_op(OP_ACCESS, 20'h00000);
		send_op(OP_INSERT, 20'h00000);
		send_op(OP_INSERT, 20'hFFFFF);
		send_op(OP_INSERT, 20'h00000);
		send_op(OP_ACCESS, 20'hFFFFF);
		send_op(OP_INSERT, 20'h00001);
		send_op(OP_INSERT, 20'h80000);
		send_op(OP_INSERT, 20'h55555);
		send_op(OP_INSERT, 20'hAAAAA);
		send_op(OP_INSERT, 20'h0F0F0);
		send_op(OP_INSERT, 20'hF0F0F);
		// full store, all bits set: a whole turn before the victim
		send_op(OP_INSERT, 20'h12345);
		send_op(OP_ACCESS, 20'h55555);
		send_op(OP_INSERT, 20'h23456);
		send_op(OP_INSERT, 20'h34567);
		send_op(OP_INSERT, 20'h45678);
		// second chance for the accessed slot
		send_op(OP_INSERT, 20'h56789);
		send_op(OP_ACCESS, 20'h00000);
		send_op(OP_NOP,    20'hFFFFF);
		send_op(OP_CLEAR,  20'hFFFFF);
		send_op(OP_INSERT, 20'hFFFFF);
		send_op(OP_ACCESS, 20'h12345);
		send_op(OP_ACCESS, 20'hFFFFF);
		wait_drained();
	endtask

	task automatic test_random_phase(input int idle, input int stall, input int count);
		int k;
		idle_pct  = idle;
		stall_pct = stall;
		refill_pool();
		for (k = 0; k < count; k++)
			send_item(random_item());
		wait_drained();
	endtask

	task automatic test_backpressure();
		int k;
		idle_pct  = 0;
		stall_pct = 0;
		refill_pool();
		@(posedge clk);
		hold_asks = hold_asks + 1;
		for (k = 0; k < 40; k++)
			send_item(random_item());
		wait_drained();
	endtask

	initial begin
		reset_working_set();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_phase(0, 0, 300);
		test_random_phase(48, 0, 300);
		test_random_phase(0, 48, 300);
		test_random_phase(15, 15, 300);
		test_backpressure();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_replies.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+design
design/cprc_pkg.sv
design/cprc_ctrl.sv
design/cprc_datapath.sv
design/clock_page_replacement_core.sv
tb/testbench.sv
